@@ rtl/assert_macros.svh @@
// assertion helper macros for the pose compose block
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define PPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define PPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/ppc_pkg.sv @@
// shared types, constants and functions for planar_pose_compose
// no dependencies
`timescale 1ns / 1ps
package ppc_pkg;
  localparam int POS_WIDTH_DEF     = 32;
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAX_STAGES        = 24;
  localparam int TRIG_W            = 16;
  localparam int CW                = 34;  // cordic datapath width, Q30 plus headroom
  localparam int ZW                = 33;
  localparam logic signed [TRIG_W-1:0] TRIG_ONE = 16'sd16384;
  localparam logic [63:0] K_INF_Q30  = 64'd652032874;
  localparam logic [63:0] K_CORR_Q30 = 64'd434688583;

  typedef struct packed {
    logic        restart;
    logic [31:0] delta_x;
    logic [31:0] delta_y;
    logic [15:0] delta_angle;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pose_x;
    logic [31:0] pose_y;
    logic [15:0] pose_angle;
    logic [15:0] pose_sin;
    logic [15:0] pose_cos;
    logic        saturated;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_ROT  = 2'd2,
    ST_OUT  = 2'd3
  } back_state_t;

  function automatic logic [31:0] atan_turn32(input logic [4:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
        5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
        5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
        5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
        5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
        5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
        5'd16: r = 32'd10431;     5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
        5'd20: r = 32'd652;       5'd21: r = 32'd326;
        5'd22: r = 32'd163;       5'd23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

  // round shift then clip a Q30 value to Q2.14
  function automatic logic signed [TRIG_W-1:0] to_q14(input logic signed [CW-1:0] v);
    logic signed [CW:0] t;
    logic signed [CW:0] q;
    logic signed [TRIG_W-1:0] r;
    begin
      t = $signed({v[CW-1], v}) + $signed((CW+1)'(32768));
      q = t >>> 16;
      if (q > $signed((CW+1)'(16384))) r = TRIG_ONE;
      else if (q < -$signed((CW+1)'(16384))) r = -TRIG_ONE;
      else r = q[TRIG_W-1:0];
      return r;
    end
  endfunction
endpackage

@@ rtl/planar_pose_compose.sv @@
// From acceptance to result valid with an idle back end, a transaction passes through
// queue write, pop, the multiply steps, the rotate iterations of one shared cordic stage
// (CORDIC_STAGES, capped at MAX_STAGES) and the output load; queue wait and output stalls add to it.
// The back end takes a new transaction only after it has loaded the output of the last one;
// a two-entry queue takes new transactions while the back end works.
// Reset: synchronous active-low rst_n restores the identity pose.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module planar_pose_compose #(
  parameter int POS_WIDTH     = ppc_pkg::POS_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = ppc_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = ppc_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ppc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ppc_pkg::out_item_t out_data
);
  logic q_valid, q_pop;
  ppc_pkg::in_item_t q_data;

  ppc_front #(.POS_WIDTH(POS_WIDTH), .ANGLE_WIDTH(ANGLE_WIDTH)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .q_valid, .q_pop, .q_data
  );

  ppc_back #(.POS_WIDTH(POS_WIDTH), .ANGLE_WIDTH(ANGLE_WIDTH),
             .CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_data, .out_valid, .out_stall, .out_data
  );

  `PPC_ASSERT_IMP(a_pop_valid, clk, rst_n, q_pop, q_valid)
  `PPC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                   out_valid && $stable(out_data))
  `PPC_ASSERT_IMP(a_trig_range, clk, rst_n, out_valid,
                  $signed(out_data.pose_cos) <= 16'sd16384 &&
                  $signed(out_data.pose_cos) >= -16'sd16384)
endmodule

@@ rtl/ppc_front.sv @@
// front end: accepts transactions and queues them for the back end
// depends on ppc_pkg
`timescale 1ns / 1ps
module ppc_front #(
  parameter int POS_WIDTH   = ppc_pkg::POS_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ppc_pkg::ANGLE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ppc_pkg::in_item_t in_data,
  output logic             q_valid,
  input  logic             q_pop,
  output ppc_pkg::in_item_t q_data
);
  // two-entry queue
  ppc_pkg::in_item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (q_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  // classify: mask fields to parameter widths
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r].restart <= in_data.restart;
      mem_r[wp_r].delta_x <= 32'($signed(in_data.delta_x[POS_WIDTH-1:0]));
      mem_r[wp_r].delta_y <= 32'($signed(in_data.delta_y[POS_WIDTH-1:0]));
      mem_r[wp_r].delta_angle <= 16'(in_data.delta_angle[ANGLE_WIDTH-1:0]);
    end
  end
endmodule

@@ rtl/ppc_back.sv @@
// back end: translation update then iterative cordic of new heading
// depends on ppc_pkg
`timescale 1ns / 1ps
module ppc_back #(
  parameter int POS_WIDTH     = ppc_pkg::POS_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = ppc_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = ppc_pkg::CORDIC_STAGES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  ppc_pkg::in_item_t q_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ppc_pkg::out_item_t out_data
);
  localparam int NST = (CORDIC_STAGES > ppc_pkg::MAX_STAGES) ? ppc_pkg::MAX_STAGES
                                                              : CORDIC_STAGES;
  localparam int PW = 2 * POS_WIDTH + 20;
  localparam logic [63:0] K0 = ppc_pkg::K_INF_Q30 + (ppc_pkg::K_CORR_Q30 >> (2 * NST));
  localparam logic signed [PW-1:0] PMAX = (PW'(1) <<< (POS_WIDTH - 1)) - PW'(1);
  localparam logic signed [PW-1:0] PMIN = -PMAX - PW'(1);

  ppc_pkg::back_state_t st_r, st_nxt;
  logic signed [POS_WIDTH-1:0] acc_x_r, acc_y_r;
  logic [ANGLE_WIDTH-1:0] acc_ang_r;
  logic signed [15:0] acc_sin_r, acc_cos_r;
  logic signed [POS_WIDTH-1:0] dx_r, dy_r;
  logic signed [POS_WIDTH-1:0] bx_r, by_r;
  logic signed [15:0] s_r, c_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r;
  logic [1:0] mcnt_r;
  logic signed [ppc_pkg::CW-1:0] cx_r, cy_r;
  logic signed [ppc_pkg::ZW-1:0] cz_r;
  logic [1:0] quad_r;
  logic [4:0] it_r;
  logic sat_r;
  logic ov_r;
  ppc_pkg::out_item_t ob_r;

  logic signed [PW-1:0] nx, ny, rx, ry;
  logic [ANGLE_WIDTH-1:0] nang;
  logic signed [ppc_pkg::CW-1:0] xs, ys;
  logic signed [ppc_pkg::ZW-1:0] at;
  logic signed [15:0] cq, sq;
  logic hx_lo, hx_hi, hy_lo, hy_hi;

  assign out_valid = ov_r;
  assign out_data = ob_r;

  always_comb begin
    nx = p0_r - p1_r + (PW'(acc_x_r) <<< 14) + PW'(8192);
    ny = p2_r + p3_r + (PW'(acc_y_r) <<< 14) + PW'(8192);
    nx = nx >>> 14;
    ny = ny >>> 14;
    hx_hi = nx > PMAX; hx_lo = nx < PMIN;
    hy_hi = ny > PMAX; hy_lo = ny < PMIN;
    rx = hx_hi ? PMAX : (hx_lo ? PMIN : nx);
    ry = hy_hi ? PMAX : (hy_lo ? PMIN : ny);
    nang = acc_ang_r + q_data.delta_angle[ANGLE_WIDTH-1:0];
    xs = cx_r >>> it_r;
    ys = cy_r >>> it_r;
    at = ppc_pkg::ZW'(ppc_pkg::atan_turn32(it_r));
    cq = ppc_pkg::to_q14(cx_r);
    sq = ppc_pkg::to_q14(cy_r);
  end

  always_comb begin
    st_nxt = st_r;
    q_pop = 1'b0;
    unique case (st_r)
      ppc_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          st_nxt = ppc_pkg::ST_MUL;
        end
      end
      ppc_pkg::ST_MUL: if (mcnt_r == 2'd2) st_nxt = ppc_pkg::ST_ROT;
      ppc_pkg::ST_ROT: if (it_r == 5'(NST - 1)) st_nxt = ppc_pkg::ST_OUT;
      ppc_pkg::ST_OUT: if (!ov_r || !out_stall) st_nxt = ppc_pkg::ST_IDLE;
      default: st_nxt = ppc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ppc_pkg::ST_IDLE;
      ov_r <= 1'b0;
      acc_x_r <= '0;
      acc_y_r <= '0;
      acc_ang_r <= '0;
      acc_sin_r <= '0;
      acc_cos_r <= ppc_pkg::TRIG_ONE;
    end else begin
      st_r <= st_nxt;
      if (st_r == ppc_pkg::ST_OUT && (!ov_r || !out_stall)) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      unique case (st_r)
        ppc_pkg::ST_IDLE: if (q_valid) begin
          // restart folds in identity state
          if (q_data.restart) begin
            acc_x_r <= '0;
            acc_y_r <= '0;
          end
          s_r <= q_data.restart ? 16'sd0 : acc_sin_r;
          c_r <= q_data.restart ? ppc_pkg::TRIG_ONE : acc_cos_r;
          dx_r <= q_data.delta_x[POS_WIDTH-1:0];
          dy_r <= q_data.delta_y[POS_WIDTH-1:0];
          acc_ang_r <= q_data.restart ? q_data.delta_angle[ANGLE_WIDTH-1:0] : nang;
          mcnt_r <= 2'd0;
        end
        ppc_pkg::ST_MUL: begin
          // four POS_WIDTH x 16 products over the multiply phase, the last two together
          mcnt_r <= mcnt_r + 2'd1;
          unique case (mcnt_r)
            2'd0: begin
              p0_r <= PW'(dx_r) * PW'(c_r);
              phase_load();
            end
            2'd1: p1_r <= PW'(dy_r) * PW'(s_r);
            2'd2: p2_r <= PW'(dx_r) * PW'(s_r);
            default: ;
          endcase
          if (mcnt_r == 2'd2) begin
            p3_r <= PW'(dy_r) * PW'(c_r);
            it_r <= 5'd0;
          end
        end
        ppc_pkg::ST_ROT: begin
          if (it_r == 5'd0) begin
            bx_r <= rx[POS_WIDTH-1:0];
            by_r <= ry[POS_WIDTH-1:0];
            sat_r <= hx_hi | hx_lo | hy_hi | hy_lo;
          end
          if (!cz_r[ppc_pkg::ZW-1]) begin
            cx_r <= cx_r - ys; cy_r <= cy_r + xs; cz_r <= cz_r - at;
          end else begin
            cx_r <= cx_r + ys; cy_r <= cy_r - xs; cz_r <= cz_r + at;
          end
          it_r <= it_r + 5'd1;
        end
        ppc_pkg::ST_OUT: if (!ov_r || !out_stall) begin
          acc_x_r <= bx_r;
          acc_y_r <= by_r;
          ob_r.pose_x <= 32'($unsigned(bx_r));
          ob_r.pose_y <= 32'($unsigned(by_r));
          ob_r.pose_angle <= 16'(acc_ang_r);
          ob_r.saturated <= sat_r;
          unique case (quad_r)
            2'd0: begin
              acc_cos_r <= cq; acc_sin_r <= sq; ob_r.pose_cos <= cq; ob_r.pose_sin <= sq;
            end
            2'd1: begin
              acc_cos_r <= -sq; acc_sin_r <= cq; ob_r.pose_cos <= -sq; ob_r.pose_sin <= cq;
            end
            2'd2: begin
              acc_cos_r <= -cq; acc_sin_r <= -sq; ob_r.pose_cos <= -cq; ob_r.pose_sin <= -sq;
            end
            default: begin
              acc_cos_r <= sq; acc_sin_r <= -cq; ob_r.pose_cos <= sq; ob_r.pose_sin <= -cq;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // cordic seed from the stored heading
  task automatic phase_load();
    logic [31:0] ph;
    ph = 32'({acc_ang_r, {(32 - ANGLE_WIDTH){1'b0}}});
    quad_r <= ph[31:30];
    cz_r <= ppc_pkg::ZW'(ph[29:0]);
    cx_r <= ppc_pkg::CW'(K0);
    cy_r <= '0;
  endtask
endmodule

@@ tb/tb.sv @@
// testbench for planar_pose_compose: random and directed odometry transactions
// checked against an in-bench pose predictor; depends on ppc_pkg and the rtl
`timescale 1ns / 1ps
module tb;
  import ppc_pkg::*;

  localparam int NSTAGES = 16;
  localparam logic [63:0] KNF = 64'd652032874;
  localparam logic [63:0] KCR = 64'd434688583;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  planar_pose_compose u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted pose state
  longint pose_x_q, pose_y_q, sin_q, cos_q;
  logic [15:0] head_q;

  in_item_t pending_q[$];
  out_item_t pose_expect_q[$];
  int errors = 0;
  bit quiet = 1'b0;
  bit hold_in = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  bit stim_done = 1'b0;

  function automatic longint atan_tab(int i);
    longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772,
                      166886, 83443, 41722, 20861, 10431, 5215,
                      2608, 1304, 652, 326, 163, 81};
    return t[i];
  endfunction

  function automatic longint q14_of(longint v);
    longint q;
    q = (v + 32768) >>> 16;
    if (q > 16384) q = 16384;
    if (q < -16384) q = -16384;
    return q;
  endfunction

  function automatic longint clip_pos(longint v, ref bit hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic void heading_trig(logic [15:0] a, output longint s, output longint c);
    logic [31:0] ph;
    longint x, y, z, xs, ys, cc, ss;
    ph = {a, 16'd0};
    z = longint'(ph[29:0]);
    x = longint'(KNF) + (longint'(KCR) >>> (2 * NSTAGES));
    y = 0;
    for (int i = 0; i < NSTAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - atan_tab(i);
      end else begin
        x = x + ys; y = y - xs; z = z + atan_tab(i);
      end
    end
    cc = q14_of(x);
    ss = q14_of(y);
    case (ph[31:30])
      2'd0: begin c = cc; s = ss; end
      2'd1: begin c = -ss; s = cc; end
      2'd2: begin c = -cc; s = -ss; end
      default: begin c = ss; s = -cc; end
    endcase
  endfunction

  function automatic out_item_t compose_pose(in_item_t it);
    longint dx, dy, nx, ny;
    bit hit;
    out_item_t r;
    hit = 1'b0;
    dx = longint'($signed(it.delta_x));
    dy = longint'($signed(it.delta_y));
    if (it.restart) begin
      pose_x_q = 0; pose_y_q = 0; head_q = '0; sin_q = 0; cos_q = 16384;
    end
    nx = dx * cos_q - dy * sin_q + pose_x_q * 16384;
    ny = dx * sin_q + dy * cos_q + pose_y_q * 16384;
    pose_x_q = clip_pos((nx + 8192) >>> 14, hit);
    pose_y_q = clip_pos((ny + 8192) >>> 14, hit);
    head_q = head_q + it.delta_angle;
    heading_trig(head_q, sin_q, cos_q);
    r.pose_x = pose_x_q[31:0];
    r.pose_y = pose_y_q[31:0];
    r.pose_angle = head_q;
    r.pose_sin = sin_q[15:0];
    r.pose_cos = cos_q[15:0];
    r.saturated = hit;
    return r;
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 255) << 16;
      3: return -($urandom_range(0, 255) << 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.restart = ($urandom_range(0, 19) == 0);
    it.delta_x = rand_pos();
    it.delta_y = rand_pos();
    it.delta_angle = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 64)) : 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t mk(bit r, logic [31:0] x, logic [31:0] y, logic [15:0] a);
    in_item_t it;
    it.restart = r; it.delta_x = x; it.delta_y = y; it.delta_angle = a;
    return it;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pose_expect_q.push_back(compose_pose(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0 && !hold_in &&
                     !(in_valid && !in_stall && !quiet && $urandom_range(0, 5) == 0)) begin
          in_data <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (in_valid && !in_stall && !quiet && pending_q.size() > 0 && !hold_in)
            in_gap <= $urandom_range(0, 3);
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pose_expect_q.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          e = pose_expect_q.pop_front();
          if (out_data.pose_x !== e.pose_x) begin
            $error("pose_x exp %h got %h", e.pose_x, out_data.pose_x); errors++;
          end
          if (out_data.pose_y !== e.pose_y) begin
            $error("pose_y exp %h got %h", e.pose_y, out_data.pose_y); errors++;
          end
          if (out_data.pose_angle !== e.pose_angle) begin
            $error("pose_angle exp %h got %h", e.pose_angle, out_data.pose_angle); errors++;
          end
          if (out_data.pose_sin !== e.pose_sin) begin
            $error("pose_sin exp %h got %h", e.pose_sin, out_data.pose_sin); errors++;
          end
          if (out_data.pose_cos !== e.pose_cos) begin
            $error("pose_cos exp %h got %h", e.pose_cos, out_data.pose_cos); errors++;
          end
          if (out_data.saturated !== e.saturated) begin
            $error("saturated exp %b got %b", e.saturated, out_data.saturated); errors++;
          end
        end
      end
      // stall in random bursts
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #50ms;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    pose_x_q = 0; pose_y_q = 0; head_q = '0; sin_q = 0; cos_q = 16384;
    // directed: extremes, wraps, saturation, restart
    pending_q.push_back(mk(0, 32'h0001_0000, 32'h0, 16'h0));
    pending_q.push_back(mk(0, 32'h0, 32'h0, 16'h4000));
    pending_q.push_back(mk(0, 32'h0002_0000, 32'h0001_0000, 16'h4000));
    pending_q.push_back(mk(0, 32'h0, 32'h0, 16'h4000));
    pending_q.push_back(mk(0, 32'h0, 32'h0, 16'hffff));
    pending_q.push_back(mk(0, 32'h0, 32'h0, 16'h0001));
    pending_q.push_back(mk(1, 32'h7fff_ffff, 32'h7fff_ffff, 16'h2000));
    pending_q.push_back(mk(0, 32'h7fff_ffff, 32'h7fff_ffff, 16'h0));
    pending_q.push_back(mk(0, 32'h8000_0000, 32'h8000_0000, 16'h8000));
    pending_q.push_back(mk(1, 32'h8000_0000, 32'h8000_0000, 16'hc000));
    pending_q.push_back(mk(0, 32'h8000_0000, 32'h7fff_ffff, 16'h6000));
    pending_q.push_back(mk(1, 32'hffff_ffff, 32'h0000_0001, 16'h8001));
    pending_q.push_back(mk(0, 32'h0000_0001, 32'hffff_ffff, 16'h7fff));
    pending_q.push_back(mk(0, 32'h5555_5555, 32'haaaa_aaaa, 16'h5555));
    pending_q.push_back(mk(0, 32'haaaa_aaaa, 32'h5555_5555, 16'haaaa));
    pending_q.push_back(mk(1, 32'h0, 32'h0, 16'h0));
    for (int i = 0; i < 400; i++) pending_q.push_back(rand_item());
    wait (pending_q.size() == 0);
    // hold the sender until everything has drained
    hold_in = 1'b1;
    wait (pose_expect_q.size() == 0 && !in_valid);
    repeat (30) @(posedge clk);
    hold_in = 1'b0;
    for (int i = 0; i < 300; i++) pending_q.push_back(rand_item());
    wait (pending_q.size() == 0);
    quiet = 1'b1;
    for (int i = 0; i < 150; i++) pending_q.push_back(rand_item());
    wait (pending_q.size() == 0);
    @(posedge clk);
    while (in_valid || pose_expect_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl
rtl/ppc_pkg.sv
rtl/ppc_front.sv
rtl/ppc_back.sv
rtl/planar_pose_compose.sv
tb/tb.sv
